### src/bitmap_block_allocator_macros.svh
// assertion helpers for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// checked only while out of reset
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bba_pkg.sv
package bba_pkg;

  localparam int NUM_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int BLK_W  = 12;  // block_index / block_number field width
  localparam int LIM_W  = 13;  // blocks_in_use field width
  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int ROW_W  = $clog2(MAP_WORDS);
  localparam int STAT_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4096);

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_DONE
  } bba_state_t;

  // {found, position} of the lowest clear bit
  function automatic logic [BIT_W:0] first_zero(input map_word_t w);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

### src/bba_in_if.sv
interface bba_in_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [BLK_W-1:0] block_index;

  modport source (output valid, cmd, block_index, input ready);
  modport sink   (input valid, cmd, block_index, output ready);
endinterface

### src/bba_out_if.sv
interface bba_out_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  block_number;
  logic [STAT_W-1:0] status;

  modport source (output valid, block_number, status, input ready);
  modport sink   (input valid, block_number, status, output ready);
endinterface

### src/bba_cfg_if.sv
interface bba_cfg_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] blocks_in_use;

  modport source (output valid, blocks_in_use, input ready);
  modport sink   (input valid, blocks_in_use, output ready);
endinterface

### src/bitmap_block_allocator.sv
// channel  dir  handshake     payload
// in_ch    in   valid/ready   cmd, block_index
// out_ch   out  valid/ready   block_number, status
// cfg_ch   in   valid/ready   blocks_in_use (always ready)
//
// free: S_FREE clears the block's bit and registers the result, then S_DONE
//   moves it into the output register
// allocate: S_SCAN reads k bitmap words (0 when the limit is zero, else 1 to 128),
//   one word per cycle through the single read port of the map RAM, then S_DONE
//   moves the result into the output register
// reset: per-row valid flops clear at once, unwritten rows read as all free
// one command in flight; a new one is taken while the last result waits,
//   and finishing stalls until the output register is free
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);

  bba_state_t state_r, state_nxt;

  logic [LIM_W-1:0]  limit_cfg_r;
  logic [BLK_W-1:0]  idx_r, idx_nxt;
  logic [ROW_W-1:0]  ptr_r, ptr_nxt;
  logic [MAP_WORDS-1:0] row_vld_r;
  logic              rd_vld_r;

  logic [BLK_W-1:0]  res_num_r, res_num_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic              res_load;

  logic              out_valid_r;
  logic [BLK_W-1:0]  out_num_r;
  logic [STAT_W-1:0] out_st_r;
  logic              out_load;

  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr, rd_addr;
  map_word_t         wr_data, rd_data;

  logic [LIM_W-1:0]  limit, limit_m1;
  logic [ROW_W-1:0]  last_row;
  map_word_t         word, over, scan_word;
  logic [BIT_W:0]    ffz;
  logic              found;
  logic              free_ok;
  logic              in_acc;

  bba_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_number = out_num_r;
  assign out_ch.status       = out_st_r;

  // allocation limit saturates at the map size
  assign limit    = (limit_cfg_r > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : limit_cfg_r;
  assign limit_m1 = limit - LIM_W'(1);
  assign last_row = limit_m1[BIT_W +: ROW_W];

  // rows never written read as all free
  assign word = rd_vld_r ? rd_data : '0;

  // in the row that holds the limit, blocks at or past it count as used
  always_comb begin
    if ({1'b0, ptr_r} == limit[LIM_W-1:BIT_W]) begin
      over = ~((map_word_t'(1) << limit[BIT_W-1:0]) - map_word_t'(1));
    end else begin
      over = '0;
    end
  end

  assign scan_word = word | over;
  assign ffz       = first_zero(scan_word);
  assign found     = ffz[BIT_W];
  assign free_ok   = {1'b0, idx_r} < LIM_W'(NUM_BLOCKS);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          idx_nxt = in_ch.block_index;
          ptr_nxt = '0;
          if (in_ch.cmd == CMD_FREE) begin
            state_nxt = S_FREE;
          end else if (limit == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FREE: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (found || (ptr_r == last_row)) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + ROW_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = ptr_r;
    wr_data     = scan_word | (map_word_t'(1) << ffz[BIT_W-1:0]);
    res_load    = 1'b0;
    res_num_nxt = '0;
    res_st_nxt  = ST_NONE_FREE;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.cmd == CMD_FREE) begin
          rd_addr = in_ch.block_index[BIT_W +: ROW_W];
        end
        if (in_acc && in_ch.cmd == CMD_ALLOC && limit == '0) begin
          res_load = 1'b1;
        end
      end
      S_FREE: begin
        wr_en       = free_ok;
        wr_addr     = idx_r[BIT_W +: ROW_W];
        wr_data     = word & ~(map_word_t'(1) << idx_r[BIT_W-1:0]);
        res_load    = 1'b1;
        res_num_nxt = idx_r;
        res_st_nxt  = ST_FREED;
      end
      S_SCAN: begin
        rd_addr = ptr_r + ROW_W'(1);
        wr_en   = found;
        // the masked bits are only ever those past the limit, which the
        // write must leave as they were
        wr_data = word | (map_word_t'(1) << ffz[BIT_W-1:0]);
        if (found) begin
          res_load    = 1'b1;
          res_num_nxt = {ptr_r, ffz[BIT_W-1:0]};
          res_st_nxt  = ST_ALLOCATED;
        end else if (ptr_r == last_row) begin
          res_load = 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_cfg_r <= LIMIT_RESET;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        limit_cfg_r <= cfg_ch.blocks_in_use;
      end
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ptr_r    <= ptr_nxt;
    rd_vld_r <= row_vld_r[rd_addr];
    if (res_load) begin
      res_num_r <= res_num_nxt;
      res_st_r  <= res_st_nxt;
    end
    if (out_load) begin
      out_num_r <= res_num_r;
      out_st_r  <= res_st_r;
    end
  end

endmodule

### src/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/bba_checker.sv
`include "bitmap_block_allocator_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BLK_W-1:0]  block_number,
  input logic [STAT_W-1:0] status
);

  logic [1:0] cnt_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken in but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  `BBA_ASSERT(a_result_has_cmd, out_valid |-> cnt_r != 2'd0, "result with no command pending")
  `BBA_ASSERT(a_one_in_flight, in_acc |-> (cnt_r == 2'd0 || cnt_r == 2'd1), "too many commands taken")
  `BBA_ASSERT(a_none_free_zero, (out_valid && status == ST_NONE_FREE) |-> block_number == '0, "none free with nonzero block")
  `BBA_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(block_number) && $stable(status)), "stalled result changed")
  `BBA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .block_number(out_ch.block_number),
  .status      (out_ch.status)
);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam int     RANDOM_PER_MODE = 376;
  localparam int     LONG_HOLD       = 400;
  localparam int     DRAIN_CYCLES    = 200;
  localparam longint TIMEOUT_NS      = 50_000_000;

  typedef struct packed {
    logic [BLK_W-1:0]  block_number;
    logic [STAT_W-1:0] status;
  } grant_t;

  typedef enum logic [1:0] {
    ROW_ALLOC,
    ROW_FREE,
    ROW_LIMIT
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [LIM_W-1:0] value;
    bit               typed;
    grant_t           want;
  } dir_step_t;

  logic clk;
  logic rst_n;

  bba_in_if  in_ch  ();
  bba_out_if out_ch ();
  bba_cfg_if cfg_ch ();

  bitmap_block_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block's bitmap and limit register
  bit               block_used [NUM_BLOCKS];
  logic [LIM_W-1:0] limit_reg = LIMIT_RESET;
  int               high_water = 0;
  grant_t           pending_grants [$];

  // typed-in expectation travels with the transaction on the input channel
  bit               item_typed;
  grant_t           item_typed_grant;

  dir_step_t        dir_steps [$];
  int               fail_count = 0;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               hold_requests = 0;
  int               hold_served = 0;
  int               hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("bitmap_block_allocator verification failed");
    $finish;
  end

  function automatic grant_t predict_grant(input logic c, input logic [BLK_W-1:0] idx);
    grant_t g;
    int     span;
    if (c == CMD_FREE) begin
      block_used[idx] = 1'b0;
      g.block_number  = idx;
      g.status        = ST_FREED;
      return g;
    end
    span           = (limit_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(limit_reg);
    g.block_number = '0;
    g.status       = ST_NONE_FREE;
    for (int b = 0; b < span; b++) begin
      if (!block_used[b]) begin
        block_used[b]  = 1'b1;
        g.block_number = BLK_W'(b);
        g.status       = ST_ALLOCATED;
        if (b > high_water) high_water = b;
        break;
      end
    end
    return g;
  endfunction

  // mostly a block that is really in use, sometimes any index
  function automatic logic [BLK_W-1:0] pick_free_target(input int span);
    int top;
    int pick;
    if ($urandom_range(99) < 15) return BLK_W'($urandom);
    top = (span > 0 && $urandom_range(1) == 1) ? span - 1 : high_water;
    for (int t = 0; t < 16; t++) begin
      pick = $urandom_range(top);
      if (block_used[pick]) return BLK_W'(pick);
    end
    return BLK_W'($urandom);
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_grants.size() == 0) begin
          $error("result with nothing pending: block_number %0d status %0d",
                 out_ch.block_number, out_ch.status);
          fail_count++;
        end else begin
          want = pending_grants.pop_front();
          if (out_ch.block_number !== want.block_number) begin
            $error("block_number mismatch: expected %0d, actual %0d",
                   want.block_number, out_ch.block_number);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = predict_grant(in_ch.cmd, in_ch.block_index);
        if (item_typed) want = item_typed_grant;
        pending_grants.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) limit_reg = cfg_ch.blocks_in_use;
    end
  end

  // result side: random backpressure, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic c, input logic [BLK_W-1:0] idx, input bit typed,
                           input grant_t typed_want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.block_index <= idx;
    item_typed        <= typed;
    item_typed_grant  <= typed_want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    wait_idle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.blocks_in_use <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_step(input row_kind_t k, input int v, input bit typed, input int num,
                          input logic [STAT_W-1:0] st);
    dir_step_t s;
    s.kind              = k;
    s.value             = LIM_W'(v);
    s.typed             = typed;
    s.want.block_number = BLK_W'(num);
    s.want.status       = st;
    dir_steps.push_back(s);
  endtask

  task automatic run_random(input int count);
    int               left;
    int               n;
    int               alloc_pct;
    int               phase;
    int               span;
    logic [LIM_W-1:0] lim;
    left  = count;
    phase = 0;
    while (left > 0) begin
      case ($urandom_range(9))
        0:       lim = '0;
        1:       lim = LIM_W'(1);
        2, 3:    lim = LIM_W'($urandom_range(2, 40));
        4, 5:    lim = LIM_W'($urandom_range(41, 1200));
        6, 7:    lim = LIM_W'(NUM_BLOCKS);
        8:       lim = LIM_W'($urandom_range(NUM_BLOCKS + 1, 8191));
        default: lim = '1;
      endcase
      write_limit(lim);
      span      = (lim > NUM_BLOCKS) ? NUM_BLOCKS : int'(lim);
      alloc_pct = (phase % 5 == 4) ? 95 : $urandom_range(45, 85);
      n         = $urandom_range(40, 100);
      if (n > left) n = left;
      for (int j = 0; j < n; j++) begin
        if (j == n / 2 && phase % 4 == 1) hold_requests++;
        if (j == n / 2 && phase % 4 == 3) wait_idle();
        if ($urandom_range(99) < alloc_pct)
          send_item(CMD_ALLOC, BLK_W'($urandom), 1'b0, '0);
        else
          send_item(CMD_FREE, pick_free_target(span), 1'b0, '0);
      end
      left -= n;
      phase++;
    end
  endtask

  initial begin
    logic c;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_ALLOC;
    in_ch.block_index    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.blocks_in_use <= LIMIT_RESET;
    item_typed           <= 1'b0;
    item_typed_grant     <= '0;
    tx_idle_pct = 29;
    rx_idle_pct = 47;

    // fresh map, reset limit
    add_step(ROW_ALLOC, 0, 1, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 1, 1, ST_ALLOCATED);
    add_step(ROW_ALLOC, 'hFFF, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 'h800, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_FREE, 'hFFF, 1, 'hFFF, ST_FREED);  // already free
    add_step(ROW_FREE, 0, 1, 0, ST_FREED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    // nothing managed
    add_step(ROW_LIMIT, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 1, 0, ST_NONE_FREE);
    add_step(ROW_FREE, 'hAAA, 1, 'hAAA, ST_FREED);
    // limit below blocks already in use, then free one above it
    add_step(ROW_LIMIT, 3, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_FREE, 4, 1, 4, ST_FREED);
    add_step(ROW_FREE, 1, 1, 1, ST_FREED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    // limits past the map saturate
    add_step(ROW_LIMIT, 8191, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 'hFFF, 0, 0, ST_ALLOCATED);
    add_step(ROW_FREE, 'h555, 1, 'h555, ST_FREED);
    add_step(ROW_LIMIT, NUM_BLOCKS + 1, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_LIMIT, 1, 0, 0, ST_ALLOCATED);
    add_step(ROW_FREE, 0, 1, 0, ST_FREED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);
    add_step(ROW_ALLOC, 0, 1, 0, ST_NONE_FREE);
    add_step(ROW_LIMIT, NUM_BLOCKS, 0, 0, ST_ALLOCATED);
    add_step(ROW_FREE, 'hFFF, 1, 'hFFF, ST_FREED);
    add_step(ROW_ALLOC, 0, 0, 0, ST_ALLOCATED);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_LIMIT) begin
        write_limit(dir_steps[i].value);
      end else begin
        c = (dir_steps[i].kind == ROW_FREE) ? CMD_FREE : CMD_ALLOC;
        send_item(c, dir_steps[i].value[BLK_W-1:0], dir_steps[i].typed, dir_steps[i].want);
      end
    end

    run_random(RANDOM_PER_MODE);
    tx_idle_pct = 47;
    rx_idle_pct = 29;
    run_random(RANDOM_PER_MODE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_PER_MODE);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $error("%0d expected results never arrived", pending_grants.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("bitmap_block_allocator verification clean");
    end else begin
      $display("bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule

### bitmap_block_allocator.f
+incdir+src
src/bba_pkg.sv
src/bba_in_if.sv
src/bba_out_if.sv
src/bba_cfg_if.sv
src/bba_ram.sv
src/bitmap_block_allocator.sv
src/bba_checker.sv
verif/tb_top.sv
